>>> rtl/flame_ifs_point_step_assert.svh
// Assertion macros for the flame IFS point step block.
// Used by the top level; the including module must provide clk and arst_n.
`ifndef FLAME_IFS_POINT_STEP_ASSERT_SVH
`define FLAME_IFS_POINT_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
`define FIPS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("fips assertion failed");
`define FIPS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("fips assertion failed");
`else
`define FIPS_ASSERT(lbl, prop)
`define FIPS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/fips_pkg.sv
// Shared types and constants of the flame IFS point step block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package fips_pkg;
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	localparam int NCOEF = 9;
	localparam logic [32:0] TWO_PI_Q = 33'd105414357;
	localparam logic [32:0] MOD_OFS = 33'd2213701497;
	localparam logic signed [27:0] PI_Q = 28'sd52707179;
	localparam logic signed [27:0] TWO_PI_S = 28'sd105414357;
	localparam logic signed [27:0] HALF_PI_Q = 28'sd26353589;
	localparam logic [24:0] ONE_Q = 25'h1000000;
	localparam logic [6:0] INV_STEPS = 7'd80;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_START, OP_BEGIN, OP_RD, OP_MULC, OP_ACCP, OP_ACCC,
		OP_ROW, OP_SQ, OP_SQACC, OP_ZERO, OP_INVGO, OP_INVFIN, OP_MODI, OP_MODS,
		OP_FOLD, OP_SQA, OP_R2, OP_MULT, OP_DIVC, OP_TUPD, OP_MULAT, OP_SINFIN,
		OP_DONE, OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
		logic [1:0] row;
		logic [1:0] k;
		logic [1:0] ci;
		logic [2:0] mstep;
		logic [2:0] j;
	} dp_ctl_t;

	typedef struct packed {
		logic var_sine;
		logic s_zero;
		logic div_busy;
	} dp_stat_t;

	// Reciprocals of the sine series divisors, scaled by 2^34 and rounded up.
	// They give the exact floored quotient for any dividend below 2^26.
	function automatic logic [31:0] sine_recip(input logic [2:0] j);
		logic [31:0] m;
		unique case (j)
			3'd0: m = 32'd156180629;
			3'd1: m = 32'd238609295;
			3'd2: m = 32'd409044505;
			3'd3: m = 32'd858993460;
			default: m = 32'd2863311531;
		endcase
		return m;
	endfunction
endpackage
`default_nettype wire

>>> rtl/fips_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Uses no package; instantiated by the datapath.
`timescale 1ns / 1ps
`default_nettype none
module fips_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [79:0] dividend,
	input  wire logic [63:0] divisor,
	input  wire logic [6:0]  count,
	output logic             busy,
	output logic [79:0]      quotient
);
	logic [79:0] dvd_q;
	logic [63:0] rem_q;
	logic [63:0] dsr_q;
	logic [79:0] quo_q;
	logic [6:0]  cnt_q;
	logic [64:0] rem_ext;
	logic [64:0] rem_sub;
	logic        ge;

	assign rem_ext = {rem_q, dvd_q[79]};
	assign rem_sub = rem_ext - {1'b0, dsr_q};
	assign ge = rem_ext >= {1'b0, dsr_q};
	assign busy = cnt_q != 7'd0;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (go) begin
			cnt_q <= count;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= 64'd0;
			quo_q <= 80'd0;
		end else if (busy) begin
			dvd_q <= {dvd_q[78:0], 1'b0};
			rem_q <= ge ? rem_sub[63:0] : rem_ext[63:0];
			quo_q <= {quo_q[78:0], ge};
		end
	end
endmodule
`default_nettype wire

>>> rtl/fips_dp.sv
// Datapath: coefficient memory, shared multiplier, divider, point registers and sine reduction.
// Depends on fips_pkg and fips_div; driven by the controller through dp_ctl_t.
`timescale 1ns / 1ps
`default_nettype none
module fips_dp import fips_pkg::*; #(
	parameter int LAYER_SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_ctl_t            ctl,
	output dp_stat_t                stat,
	input  wire logic [3:0]         layer,
	input  wire logic [3:0]         coef_index,
	input  wire logic               variant,
	input  wire logic signed [31:0] value_a,
	input  wire logic signed [31:0] value_b,
	input  wire logic signed [31:0] value_c,
	output logic signed [31:0]      point_x,
	output logic signed [31:0]      point_y,
	output logic signed [31:0]      point_z,
	output logic                    saturated
);
	localparam int LW = (LAYER_SLOTS > 1) ? $clog2(LAYER_SLOTS) : 1;
	localparam int DEPTH = LAYER_SLOTS * NCOEF;
	localparam int AW = $clog2(DEPTH);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;
	logic [LW-1:0]      lay_map [16];
	logic [LW-1:0]      lay_q;
	logic               var_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [31:0] tv_q [3];
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_s1;
	logic [63:0]        s_q;
	logic               sat_q;
	logic [32:0]        u_q;
	logic [24:0]        a_q;
	logic               neg_q;
	logic [25:0]        r2_q;
	logic [24:0]        t_q;
	logic [23:0]        dq_q;
	logic signed [31:0] out_x_q, out_y_q, out_z_q;
	logic               out_sat_q;

	logic signed [31:0] ma, mb;
	logic signed [63:0] mprod;
	logic [AW-1:0]      waddr, raddr;
	logic [3:0]         roff;
	logic signed [63:0] rnd_w;
	logic signed [31:0] row_val;
	logic               row_sat;
	logic signed [31:0] cur_v;
	logic [31:0]        mag_w;
	logic signed [31:0] inv_val;
	logic               inv_sat;
	logic [32:0]        mod_sub;
	logic signed [27:0] r0, r1;
	logic [32:0]        zsum;
	logic               div_go;
	logic [79:0]        div_dvd;
	logic [63:0]        div_dsr;
	logic [6:0]         div_cnt;
	logic               div_busy;
	logic [79:0]        div_quo;
	logic [24:0]        sin_mag;
	logic [57:0]        rcp_prod;

	for (genvar g = 0; g < 16; g++) begin : g_lay
		assign lay_map[g] = LW'(g % LAYER_SLOTS);
	end

	assign waddr = (AW'(lay_map[layer]) << 3) + AW'(lay_map[layer]) + AW'(coef_index);
	assign roff = ({2'b00, ctl.row} << 1) + {2'b00, ctl.row} + {2'b00, ctl.k};
	assign raddr = (AW'(lay_q) << 3) + AW'(lay_q) + AW'(roff);

	always_comb begin
		ma = 32'sd0;
		mb = 32'sd0;
		unique case (ctl.op)
			OP_MULC: begin
				ma = rdata_q;
				mb = (ctl.k == 2'd0) ? px_q : py_q;
			end
			OP_SQ: begin
				ma = tv_q[ctl.ci];
				mb = tv_q[ctl.ci];
			end
			OP_SQA: begin
				ma = {7'd0, a_q};
				mb = {7'd0, a_q};
			end
			OP_MULT: begin
				ma = {6'd0, r2_q};
				mb = {7'd0, t_q};
			end
			OP_MULAT: begin
				ma = {7'd0, a_q};
				mb = {7'd0, t_q};
			end
			default: begin
			end
		endcase
	end
	assign mprod = ma * mb;

	always_comb begin
		rnd_w = (acc_q + 64'sd32768) >>> 16;
		row_sat = 1'b0;
		if (rnd_w > 64'sd2147483647) begin
			row_val = 32'sh7fffffff;
			row_sat = 1'b1;
		end else if (rnd_w < -64'sd2147483648) begin
			row_val = 32'sh80000000;
			row_sat = 1'b1;
		end else begin
			row_val = rnd_w[31:0];
		end
	end

	assign cur_v = tv_q[ctl.ci];
	assign mag_w = cur_v[31] ? (~cur_v + 32'd1) : cur_v;

	always_comb begin
		inv_sat = 1'b0;
		if (cur_v[31]) begin
			if (div_quo > 80'h80000000) begin
				inv_val = 32'sh80000000;
				inv_sat = 1'b1;
			end else begin
				inv_val = ~div_quo[31:0] + 32'd1;
			end
		end else if (div_quo > 80'h7fffffff) begin
			inv_val = 32'sh7fffffff;
			inv_sat = 1'b1;
		end else begin
			inv_val = div_quo[31:0];
		end
	end

	assign mod_sub = TWO_PI_Q << ctl.mstep;

	always_comb begin
		r0 = $signed({1'b0, u_q[26:0]});
		if (r0 >= PI_Q) begin
			r0 = r0 - TWO_PI_S;
		end
		if (r0 > HALF_PI_Q) begin
			r1 = PI_Q - r0;
		end else if (r0 < -HALF_PI_Q) begin
			r1 = -PI_Q - r0;
		end else begin
			r1 = r0;
		end
	end

	assign zsum = {pz_q[31], pz_q} + {tv_q[2][31], tv_q[2]};
	assign sin_mag = prod_s1[48:24];
	assign rcp_prod = {32'd0, prod_s1[49:24]} * {26'd0, sine_recip(ctl.j)};

	assign div_go = ctl.op == OP_INVGO;
	assign div_dvd = {mag_w, 48'd0};
	assign div_dsr = s_q;
	assign div_cnt = INV_STEPS;

	fips_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.count    (div_cnt),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD && coef_index < 4'(NCOEF)) begin
			mem[waddr] <= value_a;
		end
		if (ctl.op == OP_RD) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= 32'sd0;
			py_q <= 32'sd0;
			pz_q <= 32'sd0;
			sat_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				OP_START: begin
					px_q <= value_a;
					py_q <= value_b;
					pz_q <= value_c;
					sat_q <= 1'b0;
				end
				OP_BEGIN: sat_q <= 1'b0;
				OP_ROW: sat_q <= sat_q | row_sat;
				OP_ZERO: sat_q <= 1'b1;
				OP_INVFIN: sat_q <= sat_q | inv_sat;
				OP_DONE: begin
					px_q <= tv_q[0];
					py_q <= tv_q[1];
					pz_q <= zsum[32:1];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_BEGIN: begin
				lay_q <= lay_map[layer];
				var_q <= variant;
				acc_q <= 64'sd0;
				s_q <= 64'd0;
			end
			OP_MULC, OP_SQ, OP_SQA, OP_MULT, OP_MULAT: prod_s1 <= mprod;
			OP_ACCP: acc_q <= acc_q + (prod_s1 >>> 8);
			OP_ACCC: acc_q <= acc_q + (64'(rdata_q) <<< 16);
			OP_ROW: begin
				tv_q[ctl.row] <= row_val;
				acc_q <= 64'sd0;
			end
			OP_SQACC: s_q <= s_q + prod_s1;
			OP_ZERO: begin
				tv_q[0] <= 32'sd0;
				tv_q[1] <= 32'sd0;
				tv_q[2] <= 32'sd0;
			end
			OP_INVFIN: tv_q[ctl.ci] <= inv_val;
			OP_MODI: u_q <= {cur_v[31], cur_v} + MOD_OFS;
			OP_MODS: begin
				if (u_q >= mod_sub) begin
					u_q <= u_q - mod_sub;
				end
			end
			OP_FOLD: begin
				a_q <= r1[27] ? 25'(-r1) : r1[24:0];
				neg_q <= r1[27];
			end
			OP_R2: begin
				r2_q <= prod_s1[49:24];
				t_q <= ONE_Q;
			end
			OP_DIVC: dq_q <= rcp_prod[57:34];
			OP_TUPD: t_q <= ONE_Q - {1'b0, dq_q};
			OP_SINFIN: tv_q[ctl.ci] <= neg_q ? -$signed({7'd0, sin_mag}) : {7'd0, sin_mag};
			OP_OUT: begin
				out_x_q <= px_q;
				out_y_q <= py_q;
				out_z_q <= pz_q;
				out_sat_q <= sat_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.var_sine = var_q;
	assign stat.s_zero = s_q == 64'd0;
	assign stat.div_busy = div_busy;
	assign point_x = out_x_q;
	assign point_y = out_y_q;
	assign point_z = out_z_q;
	assign saturated = out_sat_q;
endmodule
`default_nettype wire

>>> rtl/fips_ctrl.sv
// Controller state machine sequencing load, start and step transfers.
// Depends on fips_pkg; issues dp_ctl_t commands and reads dp_stat_t status.
`timescale 1ns / 1ps
`default_nettype none
module fips_ctrl import fips_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] cmd,
	output logic            out_valid,
	input  wire logic       out_ready,
	output dp_ctl_t         ctl,
	input  wire dp_stat_t   stat
);
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_RD     = 5'd1;
	localparam logic [4:0] S_MUL    = 5'd2;
	localparam logic [4:0] S_ACC    = 5'd3;
	localparam logic [4:0] S_ROW    = 5'd4;
	localparam logic [4:0] S_SQ     = 5'd5;
	localparam logic [4:0] S_SQACC  = 5'd6;
	localparam logic [4:0] S_ZCHK   = 5'd7;
	localparam logic [4:0] S_INVGO  = 5'd8;
	localparam logic [4:0] S_INVWT  = 5'd9;
	localparam logic [4:0] S_INVFIN = 5'd10;
	localparam logic [4:0] S_MODI   = 5'd11;
	localparam logic [4:0] S_MODS   = 5'd12;
	localparam logic [4:0] S_FOLD   = 5'd13;
	localparam logic [4:0] S_SQA    = 5'd14;
	localparam logic [4:0] S_R2     = 5'd15;
	localparam logic [4:0] S_MULT   = 5'd16;
	localparam logic [4:0] S_DIVGO  = 5'd17;
	localparam logic [4:0] S_TUPD   = 5'd19;
	localparam logic [4:0] S_MULAT  = 5'd20;
	localparam logic [4:0] S_SINFIN = 5'd21;
	localparam logic [4:0] S_DONE   = 5'd22;
	localparam logic [4:0] S_FIN    = 5'd23;

	logic [4:0] state_q, state_d;
	logic [1:0] row_q, row_d, k_q, k_d, ci_q, ci_d;
	logic [2:0] m_q, m_d, j_q, j_d;
	logic       ov_q, ov_d;
	op_t        op;

	assign in_ready = state_q == S_IDLE;
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		row_d = row_q;
		k_d = k_q;
		ci_d = ci_q;
		m_d = m_q;
		j_d = j_q;
		ov_d = ov_q && !out_ready;
		op = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (cmd)
						CMD_LOAD: op = OP_LOAD;
						CMD_START: begin
							op = OP_START;
							state_d = S_FIN;
						end
						CMD_STEP: begin
							op = OP_BEGIN;
							row_d = 2'd0;
							k_d = 2'd0;
							state_d = S_RD;
						end
						default: begin
						end
					endcase
				end
			end
			S_RD: begin
				op = OP_RD;
				state_d = S_MUL;
			end
			S_MUL: begin
				if (k_q == 2'd2) begin
					op = OP_ACCC;
					state_d = S_ROW;
				end else begin
					op = OP_MULC;
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				op = OP_ACCP;
				k_d = k_q + 2'd1;
				state_d = S_RD;
			end
			S_ROW: begin
				op = OP_ROW;
				k_d = 2'd0;
				ci_d = 2'd0;
				if (row_q != 2'd2) begin
					row_d = row_q + 2'd1;
					state_d = S_RD;
				end else begin
					state_d = stat.var_sine ? S_MODI : S_SQ;
				end
			end
			S_SQ: begin
				op = OP_SQ;
				state_d = S_SQACC;
			end
			S_SQACC: begin
				op = OP_SQACC;
				if (ci_q != 2'd2) begin
					ci_d = ci_q + 2'd1;
					state_d = S_SQ;
				end else begin
					ci_d = 2'd0;
					state_d = S_ZCHK;
				end
			end
			S_ZCHK: begin
				if (stat.s_zero) begin
					op = OP_ZERO;
					state_d = S_DONE;
				end else begin
					state_d = S_INVGO;
				end
			end
			S_INVGO: begin
				op = OP_INVGO;
				state_d = S_INVWT;
			end
			S_INVWT: begin
				if (!stat.div_busy) begin
					state_d = S_INVFIN;
				end
			end
			S_INVFIN: begin
				op = OP_INVFIN;
				if (ci_q != 2'd2) begin
					ci_d = ci_q + 2'd1;
					state_d = S_INVGO;
				end else begin
					state_d = S_DONE;
				end
			end
			S_MODI: begin
				op = OP_MODI;
				m_d = 3'd5;
				state_d = S_MODS;
			end
			S_MODS: begin
				op = OP_MODS;
				if (m_q == 3'd0) begin
					state_d = S_FOLD;
				end else begin
					m_d = m_q - 3'd1;
				end
			end
			S_FOLD: begin
				op = OP_FOLD;
				state_d = S_SQA;
			end
			S_SQA: begin
				op = OP_SQA;
				state_d = S_R2;
			end
			S_R2: begin
				op = OP_R2;
				j_d = 3'd0;
				state_d = S_MULT;
			end
			S_MULT: begin
				op = OP_MULT;
				state_d = S_DIVGO;
			end
			S_DIVGO: begin
				op = OP_DIVC;
				state_d = S_TUPD;
			end
			S_TUPD: begin
				op = OP_TUPD;
				if (j_q == 3'd4) begin
					state_d = S_MULAT;
				end else begin
					j_d = j_q + 3'd1;
					state_d = S_MULT;
				end
			end
			S_MULAT: begin
				op = OP_MULAT;
				state_d = S_SINFIN;
			end
			S_SINFIN: begin
				op = OP_SINFIN;
				if (ci_q != 2'd2) begin
					ci_d = ci_q + 2'd1;
					state_d = S_MODI;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				op = OP_DONE;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!ov_q || out_ready) begin
					op = OP_OUT;
					ov_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q <= 2'd0;
			k_q <= 2'd0;
			ci_q <= 2'd0;
			m_q <= 3'd0;
			j_q <= 3'd0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q <= row_d;
			k_q <= k_d;
			ci_q <= ci_d;
			m_q <= m_d;
			j_q <= j_d;
			ov_q <= ov_d;
		end
	end

	assign ctl.op = op;
	assign ctl.row = row_q;
	assign ctl.k = k_q;
	assign ctl.ci = ci_q;
	assign ctl.mstep = m_q;
	assign ctl.j = j_q;
endmodule
`default_nettype wire

>>> rtl/flame_ifs_point_step.sv
// Top level of the flame IFS point step block: controller plus datapath.
// Depends on fips_pkg, fips_ctrl, fips_dp and the assertion macro header.
// One item is worked at a time; a load leaves the block idle, a start point goes to the output.
// A step first runs the affine map, which reads nine coefficients from the table,
// multiplies six of them with the point in one shared 32 by 32 multiplier and adds three.
// Variant 0 then runs three 80-step bit-serial divisions by the squared norm, or
// zeroes the point when the norm is zero; variant 1 runs fifteen
// rounds of the sine series, each a multiply and a reciprocal multiply for the
// constant divisor. Then the point is stored and, once the last point is taken, the output register loaded.
// A finished point sits in that output register, so the next transfer is taken
// while it waits.
`timescale 1ns / 1ps
`default_nettype none
`include "flame_ifs_point_step_assert.svh"
module flame_ifs_point_step import fips_pkg::*; #(
	parameter int LAYER_SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic [3:0]         layer,
	input  wire logic [3:0]         coef_index,
	input  wire logic               variant,
	input  wire logic signed [31:0] value_a,
	input  wire logic signed [31:0] value_b,
	input  wire logic signed [31:0] value_c,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      point_x,
	output logic signed [31:0]      point_y,
	output logic signed [31:0]      point_z,
	output logic                    saturated
);
	dp_ctl_t  ctl;
	dp_stat_t stat;

	fips_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	fips_dp #(
		.LAYER_SLOTS (LAYER_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.layer      (layer),
		.coef_index (coef_index),
		.variant    (variant),
		.value_a    (value_a),
		.value_b    (value_b),
		.value_c    (value_c),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.saturated  (saturated)
	);

	`FIPS_ASSERT_NEXT(a_step_busy, in_valid && in_ready && cmd == CMD_STEP, !in_ready)
	`FIPS_ASSERT_NEXT(a_start_busy, in_valid && in_ready && cmd == CMD_START, !in_ready)
	`FIPS_ASSERT_NEXT(a_load_idle, in_valid && in_ready && cmd == CMD_LOAD, in_ready)
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the flame IFS point step block: directed table, then random traffic.
// Depends on fips_pkg and the flame_ifs_point_step RTL; expected points come from a local model.
`timescale 1ns / 1ps
module testbench;
	import fips_pkg::*;

	localparam logic [1:0] CMD_IDLE = 2'd3;
	localparam int SLOTS = 16;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct {
		logic [1:0] cmd;
		logic [3:0] layer;
		logic [3:0] ci;
		logic variant;
		logic signed [31:0] a, b, c;
		bit typed;
		logic signed [31:0] ex, ey, ez;
		bit esat;
	} stim_t;

	typedef struct {
		logic signed [31:0] x, y, z;
		bit sat;
	} point_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0;
	logic in_ready, out_valid;
	logic [1:0] cmd = CMD_IDLE;
	logic [3:0] layer = 0, coef_index = 0;
	logic variant = 0;
	logic signed [31:0] value_a = 0, value_b = 0, value_c = 0;
	logic signed [31:0] point_x, point_y, point_z;
	logic saturated;

	logic signed [31:0] coef_mem [SLOTS*NCOEF];
	bit coef_set [SLOTS*NCOEF];
	logic signed [31:0] cur_x = 0, cur_y = 0, cur_z = 0;
	point_t point_q [$];
	stim_t dir_tbl [$];
	int send_idle_pct = 0, recv_idle_pct = 0;
	int idle_cycles = 0, hold_left = 0;
	bit hold_req = 0, hold_done = 0, failed = 0;

	always #4 clk = ~clk;

	flame_ifs_point_step DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .layer(layer), .coef_index(coef_index), .variant(variant),
		.value_a(value_a), .value_b(value_b), .value_c(value_c),
		.out_valid(out_valid), .out_ready(out_ready), .point_x(point_x),
		.point_y(point_y), .point_z(point_z), .saturated(saturated)
	);

	function automatic logic signed [31:0] clamp_q(longint v, inout bit sat);
		if (v > longint'(Q_MAX)) begin
			sat = 1;
			return Q_MAX;
		end
		if (v < longint'(Q_MIN)) begin
			sat = 1;
			return Q_MIN;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] affine_row(int base, inout bit sat);
		longint p0, p1, acc;
		p0 = longint'(coef_mem[base]) * longint'(cur_x);
		p1 = longint'(coef_mem[base+1]) * longint'(cur_y);
		acc = (p0 >>> 8) + (p1 >>> 8) + longint'(coef_mem[base+2]) * 65536;
		return clamp_q((acc + 32768) >>> 16, sat);
	endfunction

	function automatic logic signed [31:0] invert_q(logic signed [31:0] v, logic [63:0] den,
			inout bit sat);
		logic [127:0] num, q;
		longint mag;
		mag = (v < 0) ? -longint'(v) : longint'(v);
		num = 128'(mag) << 48;
		q = num / 128'(den);
		if (v < 0) begin
			if (q > 128'(64'd1 << 31)) begin
				sat = 1;
				return Q_MIN;
			end
			return -q[31:0];
		end
		if (q > 128'(Q_MAX)) begin
			sat = 1;
			return Q_MAX;
		end
		return q[31:0];
	endfunction

	function automatic logic signed [31:0] sine_q(logic signed [31:0] v);
		longint r, a, r2, t, s;
		longint dens [5] = '{110, 72, 42, 20, 6};
		r = longint'(v) % 105414357;
		if (r < 0) r += 105414357;
		if (r >= 52707179) r -= 105414357;
		if (r > 26353589) r = 52707179 - r;
		else if (r < -26353589) r = -52707179 - r;
		a = (r < 0) ? -r : r;
		r2 = (a * a) >> 24;
		t = 1 << 24;
		for (int i = 0; i < 5; i++) t = (1 << 24) - (((r2 * t) >> 24) / dens[i]);
		s = (a * t) >> 24;
		return (r < 0) ? -s[31:0] : s[31:0];
	endfunction

	function automatic bit flame_step(stim_t it, output point_t p);
		bit sat;
		int base;
		logic signed [31:0] x, y, z;
		logic [63:0] nrm;
		sat = 0;
		base = int'(it.layer) % SLOTS * NCOEF;
		if (it.cmd == CMD_LOAD) begin
			if (it.ci < NCOEF) coef_mem[base + it.ci] = it.a;
			return 0;
		end
		if (it.cmd == CMD_START) begin
			cur_x = it.a;
			cur_y = it.b;
			cur_z = it.c;
		end else if (it.cmd == CMD_STEP) begin
			x = affine_row(base, sat);
			y = affine_row(base + 3, sat);
			z = affine_row(base + 6, sat);
			if (!it.variant) begin
				nrm = 64'(longint'(x) * x) + 64'(longint'(y) * y) + 64'(longint'(z) * z);
				if (nrm == 0) begin
					sat = 1;
					x = 0;
					y = 0;
					z = 0;
				end else begin
					x = invert_q(x, nrm, sat);
					y = invert_q(y, nrm, sat);
					z = invert_q(z, nrm, sat);
				end
			end else begin
				x = sine_q(x);
				y = sine_q(y);
				z = sine_q(z);
			end
			cur_x = x;
			cur_y = y;
			cur_z = 32'((longint'(z) + longint'(cur_z)) >>> 1);
		end else begin
			return 0;
		end
		p = '{cur_x, cur_y, cur_z, sat};
		return 1;
	endfunction

	function automatic logic signed [31:0] rand_q();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
		if (pick < 75) return Q_MAX;
		if (pick < 80) return Q_MIN;
		return $urandom;
	endfunction

	function automatic stim_t mk(logic [1:0] c, logic [3:0] l, logic [3:0] i, logic v,
			logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] cz);
		stim_t s;
		s = '{c, l, i, v, a, b, cz, 0, 0, 0, 0, 0};
		return s;
	endfunction

	task automatic send(stim_t it);
		point_t p;
		bit has;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		cmd <= it.cmd;
		layer <= it.layer;
		coef_index <= it.ci;
		variant <= it.variant;
		value_a <= it.a;
		value_b <= it.b;
		value_c <= it.c;
		do @(posedge clk); while (!in_ready);
		has = flame_step(it, p);
		if (it.typed) p = '{it.ex, it.ey, it.ez, it.esat};
		if (has) point_q.push_back(p);
		if (it.cmd == CMD_LOAD && it.ci < NCOEF) coef_set[it.layer * NCOEF + it.ci] = 1;
		@(negedge clk);
	endtask

	function automatic bit layer_ready(int l);
		for (int k = 0; k < NCOEF; k++) if (!coef_set[l * NCOEF + k]) return 0;
		return 1;
	endfunction

	task automatic random_phase(int count);
		stim_t it;
		int pick, l;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			l = $urandom_range(SLOTS - 1);
			if (pick < 55 && layer_ready(l))
				it = mk(CMD_STEP, l, $urandom, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 65)
				it = mk(CMD_START, $urandom, $urandom, $urandom, rand_q(), rand_q(), rand_q());
			else if (pick < 67)
				it = mk(CMD_IDLE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else
				it = mk(CMD_LOAD, l, ($urandom_range(9) == 0) ? $urandom : $urandom_range(8),
					$urandom, rand_q(), $urandom, $urandom);
			send(it);
		end
	endtask

	always @(negedge clk) begin
		if (hold_req && !hold_done && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1;
			out_ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		point_t e;
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (point_q.size() == 0) begin
				$error("unexpected point transfer x=%0d y=%0d z=%0d", point_x, point_y, point_z);
				failed = 1;
			end else begin
				e = point_q.pop_front();
				if (point_x !== e.x) begin
					$error("point_x expected %0d actual %0d", e.x, point_x);
					failed = 1;
				end
				if (point_y !== e.y) begin
					$error("point_y expected %0d actual %0d", e.y, point_y);
					failed = 1;
				end
				if (point_z !== e.z) begin
					$error("point_z expected %0d actual %0d", e.z, point_z);
					failed = 1;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0d actual %0d", e.sat, saturated);
					failed = 1;
				end
			end
		end
	end

	initial begin
		stim_t s;
		logic signed [31:0] id_coef [NCOEF];
		id_coef = '{Q_ONE, 32'sh0040_0000, 32'sh0080_0000, -32'sh0020_0000, Q_ONE,
			-32'sh0100_0000, 32'sh0010_0000, 32'sh0030_0000, 32'sh0200_0000};
		for (int k = 0; k < SLOTS * NCOEF; k++) coef_set[k] = 0;
		for (int k = 0; k < NCOEF; k++) dir_tbl.push_back(mk(CMD_LOAD, 0, k, 0, id_coef[k], 0, 0));
		for (int k = 0; k < NCOEF; k++) dir_tbl.push_back(mk(CMD_LOAD, 15, k, 1, 0, -1, -1));
		dir_tbl.push_back(mk(CMD_LOAD, 0, 15, 0, Q_MAX, 0, 0));
		dir_tbl.push_back(mk(CMD_IDLE, 15, 15, 1, -1, -1, -1));
		s = mk(CMD_START, 0, 0, 0, Q_MAX, Q_MIN, Q_ONE);
		s.typed = 1;
		s.ex = Q_MAX;
		s.ey = Q_MIN;
		s.ez = Q_ONE;
		dir_tbl.push_back(s);
		dir_tbl.push_back(mk(CMD_STEP, 0, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk(CMD_STEP, 0, 0, 1, 0, 0, 0));
		s = mk(CMD_START, 0, 0, 0, 0, 0, Q_MIN);
		s.typed = 1;
		s.ez = Q_MIN;
		dir_tbl.push_back(s);
		s = mk(CMD_STEP, 15, 0, 0, 0, 0, 0);
		s.typed = 1;
		s.ez = -32'sh4000_0000;
		s.esat = 1;
		dir_tbl.push_back(s);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (dir_tbl[i]) send(dir_tbl[i]);

		send_idle_pct = 28;
		recv_idle_pct = 61;
		hold_req = 1;
		random_phase(360);
		send_idle_pct = 61;
		recv_idle_pct = 28;
		random_phase(360);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(380);
		in_valid <= 0;

		while (point_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (!failed && point_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
